FILE: hw/rtl/rle1_pkg.sv
// Package: shared types, constants and the CRC-32 byte update.
`default_nettype none
package rle1_pkg;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [2:0] RUN_TRIGGER = 3'd4;

	typedef enum logic [1:0] {
		ST_RUNNING = 2'd0,
		ST_CRC_OK = 2'd1,
		ST_CRC_BAD = 2'd2,
		ST_RUN_ERR = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CRC,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		logic fin;
		logic last;
		logic run_err;
		logic [7:0] value;
		logic [7:0] count;
	} rle1_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} rle1_qctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rle1_qstat_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'd0};
		for (int i = 0; i < 8; i++) begin
			if (c[31]) begin
				c = {c[30:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[30:0], 1'b0};
			end
		end
		return c;
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/rle1_ifs.sv
// Interfaces: byte request channel and result request channel.
`default_nettype none
interface rle1_in_if;
	logic valid;
	logic ready;
	logic [7:0] symbol;
	logic last;
	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

interface rle1_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic [7:0] out_count;
	logic [1:0] status;
	logic [31:0] crc_value;
	modport source (output valid, output out_byte, output out_count, output status,
		output crc_value, input ready);
	modport sink (input valid, input out_byte, input out_count, input status,
		input crc_value, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rle1_queue.sv
// Two-entry queue between the classifier and the CRC back end.
`default_nettype none
module rle1_queue
	import rle1_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire rle1_qctl_t ctl,
	input wire rle1_entry_t wr_entry,
	output rle1_entry_t rd_entry,
	output rle1_qstat_t stat
);
	rle1_entry_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fill_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (ctl.pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({ctl.push, ctl.pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign rd_entry = mem_q[rd_ptr_q];
	assign stat.full = fill_q[1];
	assign stat.empty = (fill_q == 2'd0);
endmodule
`default_nettype wire

FILE: hw/rtl/rle1_front.sv
// Front end: accept bytes, track equal runs, classify literal, count and post-block requests.
`default_nettype none
module rle1_front
	import rle1_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	rle1_in_if.sink byte_ch,
	input wire rle1_qstat_t qstat,
	output logic push,
	output rle1_entry_t entry
);
	logic [7:0] prev_q;
	logic [2:0] run_q;
	logic done_q;
	logic [2:0] run_next;
	logic is_count;

	assign byte_ch.ready = ~qstat.full;
	assign push = byte_ch.valid & ~qstat.full;
	assign is_count = (run_q == RUN_TRIGGER);

	always_comb begin
		if (is_count) begin
			run_next = 3'd0;
		end else if (run_q != 3'd0 && byte_ch.symbol == prev_q) begin
			run_next = run_q + 3'd1;
		end else begin
			run_next = 3'd1;
		end
		entry.fin = done_q;
		entry.last = byte_ch.last;
		entry.run_err = byte_ch.last & (run_next == RUN_TRIGGER);
		entry.value = is_count ? prev_q : byte_ch.symbol;
		entry.count = is_count ? byte_ch.symbol : 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 8'd0;
			run_q <= 3'd0;
			done_q <= 1'b0;
		end else if (push && !done_q) begin
			run_q <= run_next;
			if (!is_count) begin
				prev_q <= byte_ch.symbol;
			end
			if (byte_ch.last) begin
				done_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/rle1_back.sv
// Back end: one CRC byte update per cycle while in BK_CRC, block check and result register.
`default_nettype none
module rle1_back
	import rle1_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [31:0] expected_crc,
	input wire rle1_entry_t entry,
	input wire rle1_qstat_t qstat,
	output logic pop,
	rle1_out_if.source result_ch
);
	back_state_t state_q;
	back_state_t state_next;
	logic [31:0] crc_q;
	logic [7:0] value_q;
	logic [7:0] count_q;
	logic [7:0] rem_q;
	logic last_q;
	logic err_q;
	logic fin_q;
	logic [1:0] fstat_q;
	logic ovalid_q;
	logic [7:0] obyte_q;
	logic [7:0] ocount_q;
	logic [1:0] ostat_q;
	logic [31:0] ocrc_q;
	logic emit;
	logic step;
	logic [31:0] crc_final;
	status_t st_final;

	assign crc_final = crc_q ^ CRC_INIT;

	always_comb begin
		if (err_q) begin
			st_final = ST_RUN_ERR;
		end else if (crc_final == expected_crc) begin
			st_final = ST_CRC_OK;
		end else begin
			st_final = ST_CRC_BAD;
		end
	end

	always_comb begin
		state_next = state_q;
		pop = 1'b0;
		emit = 1'b0;
		step = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!qstat.empty) begin
					pop = 1'b1;
					state_next = BK_CRC;
				end
			end
			BK_CRC: begin
				if (rem_q == 8'd0 || fin_q) begin
					state_next = BK_EMIT;
				end else begin
					step = 1'b1;
					if (rem_q == 8'd1) begin
						state_next = BK_EMIT;
					end
				end
			end
			BK_EMIT: begin
				if (!ovalid_q || result_ch.ready) begin
					emit = 1'b1;
					if (!qstat.empty) begin
						pop = 1'b1;
						state_next = BK_CRC;
					end else begin
						state_next = BK_IDLE;
					end
				end
			end
			default: state_next = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			value_q <= entry.value;
			count_q <= entry.count;
			rem_q <= entry.count;
			last_q <= entry.last;
			err_q <= entry.run_err;
			fin_q <= entry.fin;
		end else if (step) begin
			rem_q <= rem_q - 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			fstat_q <= ST_RUNNING;
			ovalid_q <= 1'b0;
		end else begin
			if (step) begin
				crc_q <= crc_byte(crc_q, value_q);
			end else if (emit && !fin_q && last_q) begin
				crc_q <= crc_final;
				fstat_q <= st_final;
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (result_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (fin_q) begin
				obyte_q <= 8'd0;
				ocount_q <= 8'd0;
				ostat_q <= fstat_q;
				ocrc_q <= crc_q;
			end else if (last_q) begin
				obyte_q <= value_q;
				ocount_q <= count_q;
				ostat_q <= st_final;
				ocrc_q <= crc_final;
			end else begin
				obyte_q <= value_q;
				ocount_q <= count_q;
				ostat_q <= ST_RUNNING;
				ocrc_q <= crc_q;
			end
		end
	end

	assign result_ch.valid = ovalid_q;
	assign result_ch.out_byte = obyte_q;
	assign result_ch.out_count = ocount_q;
	assign result_ch.status = ostat_q;
	assign result_ch.crc_value = ocrc_q;
endmodule
`default_nettype wire

FILE: hw/rtl/rle1_run_expand_crc_top.sv
// Throughput: one CRC byte update per cycle in the back end while it is in its CRC state;
// a two-entry queue decouples input from CRC work, so requests are taken while it is busy.
// Reset: arst_n clears run tracking, queue, CRC (to all ones), held status and result valid;
// expected_crc resets to zero.
`default_nettype none
module rle1_run_expand_crc_top
	import rle1_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic expected_crc_we,
	input wire logic [31:0] expected_crc_wdata,
	rle1_in_if.sink byte_ch,
	rle1_out_if.source result_ch
);
	logic [31:0] expected_crc_q;
	rle1_entry_t wr_entry;
	rle1_entry_t rd_entry;
	rle1_qctl_t qctl;
	rle1_qstat_t qstat;
	logic push;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_crc_q <= 32'd0;
		end else if (expected_crc_we) begin
			expected_crc_q <= expected_crc_wdata;
		end
	end

	assign qctl.push = push;
	assign qctl.pop = pop;

	rle1_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.qstat(qstat),
		.push(push),
		.entry(wr_entry)
	);

	rle1_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(qctl),
		.wr_entry(wr_entry),
		.rd_entry(rd_entry),
		.stat(qstat)
	);

	rle1_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.expected_crc(expected_crc_q),
		.entry(rd_entry),
		.qstat(qstat),
		.pop(pop),
		.result_ch(result_ch)
	);
endmodule
`default_nettype wire
